@@ rtl/min_perfect_square_sum_count_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the perfect-square count block
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIN_PERFECT_SQUARE_SUM_COUNT_TOP_DEFINES_SVH
`define MIN_PERFECT_SQUARE_SUM_COUNT_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property that must hold at every edge
`define MSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define MSC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define MSC_ASSERT(lbl, prop, msg)
`define MSC_ASSERT_IMPL(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/msc_pkg.sv @@
// ----------------------------------------------------------------------------
// msc_pkg
// Shared widths, constants and types of the perfect-square count block.
// ----------------------------------------------------------------------------
package msc_pkg;

    localparam int TARGET_W            = 12;
    localparam int COUNT_W             = 3;
    localparam int COUNT_MAX           = 7;
    localparam int DEFAULT_TABLE_DEPTH = 4096;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    // Table port strobes from controller to memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } mem_ctl_t;

endpackage

@@ rtl/msc_table.sv @@
// ----------------------------------------------------------------------------
// msc_table
// Scratch table of best counts: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msc_table #(
    parameter int TABLE_DEPTH = msc_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                        clk,
    input  msc_pkg::mem_ctl_t           ctl,
    input  logic [AW-1:0]               rd_addr,
    input  logic [AW-1:0]               wr_addr,
    input  logic [msc_pkg::COUNT_W-1:0] wr_data,
    output logic [msc_pkg::COUNT_W-1:0] rd_data
);

    logic [msc_pkg::COUNT_W-1:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/msc_ctrl.sv @@
// ----------------------------------------------------------------------------
// msc_ctrl
// Sequencer: walks v up to the target (clamped to TABLE_DEPTH - 1), reads table[v - k*k]
// one per cycle while k*k <= v, folds the minimum and writes table[v] back. Holds the result register.
// ----------------------------------------------------------------------------
`include "min_perfect_square_sum_count_top_defines.svh"

module msc_ctrl #(
    parameter int TABLE_DEPTH = msc_pkg::DEFAULT_TABLE_DEPTH,
    parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [msc_pkg::TARGET_W-1:0] target,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [msc_pkg::COUNT_W-1:0]  square_count,
    output msc_pkg::mem_ctl_t            ctl,
    output logic [AW-1:0]                rd_addr,
    output logic [AW-1:0]                wr_addr,
    output logic [msc_pkg::COUNT_W-1:0]  wr_data,
    input  logic [msc_pkg::COUNT_W-1:0]  rd_data
);

    localparam int GW = (AW > msc_pkg::TARGET_W) ? AW : msc_pkg::TARGET_W;
    localparam int SW = AW + 2;
    localparam int KW = AW / 2 + 2;
    localparam int CW = msc_pkg::COUNT_W;

    msc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]   v_reg, v_next;
    logic [AW-1:0]   goal_reg, goal_next;
    logic [KW-1:0]   k_reg, k_next;
    logic [SW-1:0]   sq_reg, sq_next;
    logic [CW-1:0]   best_reg, best_next;
    logic            pend_reg, pend_next;
    logic            zero_reg, zero_next;
    logic            out_valid_reg, out_valid_next;
    logic [CW-1:0]   count_reg, count_next;

    logic [GW-1:0]   tgt_ext;
    logic [AW-1:0]   goal_clamp;
    logic [CW-1:0]   rd_val;
    logic [CW:0]     cand;
    logic [CW-1:0]   best_fold;

    always_comb
    begin
        tgt_ext = GW'(target);
        if (tgt_ext > GW'(TABLE_DEPTH - 1))
        begin
            goal_clamp = AW'(TABLE_DEPTH - 1);
        end
        else
        begin
            goal_clamp = AW'(tgt_ext);
        end
    end

    // entry 0 is never stored; a read of it counts as zero
    assign rd_val    = zero_reg ? '0 : rd_data;
    assign cand      = {1'b0, rd_val} + (CW+1)'(1);
    assign best_fold = (pend_reg && (cand < {1'b0, best_reg})) ? cand[CW-1:0] : best_reg;

    assign rd_addr = v_reg - sq_reg[AW-1:0];
    assign wr_addr = v_reg;
    assign wr_data = best_fold;

    always_comb
    begin
        state_next     = state_reg;
        v_next         = v_reg;
        goal_next      = goal_reg;
        k_next         = k_reg;
        sq_next        = sq_reg;
        best_next      = best_reg;
        pend_next      = 1'b0;
        zero_next      = 1'b0;
        out_valid_next = out_valid_reg;
        count_next     = count_reg;
        ctl            = '0;
        in_ready       = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            msc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    goal_next = goal_clamp;
                    v_next    = AW'(1);
                    k_next    = KW'(1);
                    sq_next   = SW'(1);
                    if (goal_clamp == '0)
                    begin
                        best_next  = '0;
                        state_next = msc_pkg::ST_HOLD;
                    end
                    else
                    begin
                        best_next  = CW'(1);
                        state_next = msc_pkg::ST_SCAN;
                    end
                end
            end
            msc_pkg::ST_SCAN:
            begin
                best_next = best_fold;
                if (sq_reg <= SW'(v_reg))
                begin
                    ctl.rd_en = 1'b1;
                    pend_next = 1'b1;
                    zero_next = (rd_addr == '0);
                    // (k+1)^2 = k^2 + 2k + 1
                    sq_next   = sq_reg + SW'({k_reg, 1'b0}) + SW'(1);
                    k_next    = k_reg + KW'(1);
                end
                else
                begin
                    // last read data folded this cycle; commit table[v]
                    ctl.wr_en = 1'b1;
                    if (v_reg == goal_reg)
                    begin
                        state_next = msc_pkg::ST_HOLD;
                    end
                    else
                    begin
                        v_next  = v_reg + AW'(1);
                        k_next  = KW'(1);
                        sq_next = SW'(1);
                        if (SW'(v_reg) < SW'(msc_pkg::COUNT_MAX - 1))
                        begin
                            best_next = CW'(SW'(v_reg) + SW'(1));
                        end
                        else
                        begin
                            best_next = CW'(msc_pkg::COUNT_MAX);
                        end
                    end
                end
            end
            msc_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    count_next     = best_reg;
                    state_next     = msc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= msc_pkg::ST_IDLE;
            pend_reg      <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            zero_reg      <= zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        goal_reg  <= goal_next;
        k_reg     <= k_next;
        sq_reg    <= sq_next;
        best_reg  <= best_next;
        count_reg <= count_next;
    end

    assign out_valid    = out_valid_reg;
    assign square_count = count_reg;

    `MSC_ASSERT(a_rw_excl, !(ctl.rd_en && ctl.wr_en), "table read and write in one cycle")
    `MSC_ASSERT_IMPL(a_rd_below_v, ctl.rd_en, rd_addr < v_reg, "read of entry not yet written")
    `MSC_ASSERT_IMPL(a_wr_range, ctl.wr_en, (wr_addr <= goal_reg) && (wr_addr != '0), "write outside 1..goal")
    `MSC_ASSERT_IMPL(a_count_max, out_valid_reg, count_reg <= CW'(4), "square count above four")

endmodule

@@ rtl/min_perfect_square_sum_count_top.sv @@
// For each v = 1..target the controller reads table[v - k*k] in the SCAN state, one lookup
// per cycle for every k with k*k <= v, set by the single table read port, then writes
// table[v]; target 0 goes straight to HOLD. From HOLD, out_valid rises in the same cycle
// as in_ready, as the controller returns to IDLE to take the next target.
// One transaction in flight; a finished result still waiting for out_ready stalls the input.
// Reset (rst_n, async, active low) clears control state only; table entries are rewritten.
// ----------------------------------------------------------------------------
// min_perfect_square_sum_count_top
// Fewest perfect squares summing to a target, by bottom-up table fill.
// ----------------------------------------------------------------------------
module min_perfect_square_sum_count_top #(
    parameter int TABLE_DEPTH = msc_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [msc_pkg::TARGET_W-1:0] target,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [msc_pkg::COUNT_W-1:0]  square_count
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    msc_pkg::mem_ctl_t           ctl;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [msc_pkg::COUNT_W-1:0] wr_data;
    logic [msc_pkg::COUNT_W-1:0] rd_data;

    msc_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .target       (target),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .square_count (square_count),
        .ctl          (ctl),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_data      (rd_data)
    );

    msc_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .AW          (AW)
    ) u_table (
        .clk     (clk),
        .ctl     (ctl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

endmodule
